// ===== rtl/multi_waveform_nco_top_defines.svh =====
// Assertion macros shared by the oscillator's checker.
// No dependencies; included by name where assertions are written.
`ifndef MULTI_WAVEFORM_NCO_TOP_DEFINES_SVH
`define MULTI_WAVEFORM_NCO_TOP_DEFINES_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define MWN_ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("oscillator check failed");

// Concurrent check that stays live through reset.
`define MWN_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("oscillator reset check failed");

`endif

// ===== rtl/mwn_pkg.sv =====
// Shared types, register codes and the sine table generator for the oscillator.
// No dependencies; imported by every RTL module of the block.
package mwn_pkg;

  // Configuration register file.
  localparam int CFG_INDEX_BITS = 2;
  localparam int WAVE_SEL_BITS  = 2;
  localparam int AMP_BITS       = 15;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WAVEFORM  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_AMPLITUDE = 2'd1;

  typedef enum logic [WAVE_SEL_BITS-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  localparam wave_t                WAVE_RESET = WAVE_TRIANGLE;
  localparam logic [AMP_BITS-1:0]  AMP_RESET  = 15'd16384;

  typedef struct packed {
    wave_t                waveform;
    logic [AMP_BITS-1:0]  amplitude;
  } cfg_t;

  // Queue between the phase front end and the sample back end.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Odd polynomial for sin(pi/2 * x), Q30 coefficients, lowest power first.
  localparam longint unsigned POLY_COEF [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  // One quarter-wave entry, sampled at the bin center, scaled to 2^wbits - 1.
  // Used only to build constant tables at elaboration.
  function automatic logic [31:0] sine_entry(int unsigned idx, int unsigned addr_bits,
                                              int unsigned wbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned h;
    longint unsigned p;
    longint unsigned e;
    longint unsigned full;
    x    = 64'(2 * idx + 1) << (29 - addr_bits);
    x2   = (x * x) >> 30;
    h    = POLY_COEF[5];
    full = (64'd1 << wbits) - 64'd1;
    for (int k = 4; k >= 0; k--) begin
      p = (h * x2) >> 30;
      h = (p > POLY_COEF[k]) ? 64'd0 : POLY_COEF[k] - p;
    end
    h = (h * x) >> 30;
    e = (h * full + (64'd1 << 29)) >> 30;
    if (e > full) begin
      e = full;
    end
    return e[31:0];
  endfunction

endpackage

// ===== rtl/mwn_front.sv =====
// Front end: takes increment words, saturates and scales them, runs the phase
// accumulator and queues the phase bits each sample needs. Uses mwn_pkg.
module mwn_front import mwn_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int TOP_BITS   = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [31:0]           in_phase_increment,
  output logic                  in_stall,
  input  fifo_status_t          fifo_st,
  output logic                  push,
  output logic [TOP_BITS-1:0]   push_data
);

  localparam logic [31:0] HALF_CYCLE_IN = 32'h8000_0000;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [31:0]           inc_sat;
  logic [PHASE_BITS-1:0] inc_scaled;

  // The queue alone decides whether a word can be taken.
  assign in_stall = fifo_st.full;
  assign push     = in_valid && !fifo_st.full;

  // Steps above half a cycle are held at half a cycle.
  assign inc_sat = (in_phase_increment > HALF_CYCLE_IN) ? HALF_CYCLE_IN : in_phase_increment;

  // Align the 32-bit step to the accumulator width.
  if (PHASE_BITS > 32) begin : g_inc_wide
    assign inc_scaled = {inc_sat, {(PHASE_BITS - 32){1'b0}}};
  end else if (PHASE_BITS == 32) begin : g_inc_same
    assign inc_scaled = inc_sat;
  end else begin : g_inc_narrow
    assign inc_scaled = inc_sat[31 -: PHASE_BITS];
  end

  // The sample uses the phase before this word's step.
  if (PHASE_BITS > TOP_BITS) begin : g_top_cut
    assign push_data = phase_r[PHASE_BITS-1 -: TOP_BITS];
  end else if (PHASE_BITS == TOP_BITS) begin : g_top_same
    assign push_data = phase_r;
  end else begin : g_top_pad
    assign push_data = {phase_r, {(TOP_BITS - PHASE_BITS){1'b0}}};
  end

  // The accumulator wraps naturally at its width.
  always_comb begin
    phase_nxt = phase_r;
    if (push) begin
      phase_nxt = phase_r + inc_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/mwn_fifo.sv =====
// Small register queue that decouples the phase front end from the back end.
// Uses mwn_pkg for its depth and status struct.
module mwn_fifo import mwn_pkg::*; #(
  parameter int WIDTH = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_status_t     status
);

  logic [WIDTH-1:0]         mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_nxt;
  logic [FIFO_PTR_BITS:0]   count_r;
  logic [FIFO_PTR_BITS:0]   count_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign status.full  = (count_r == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; the fill count guards it.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mwn_back.sv =====
// Back end: forms the waveform from queued phase bits, reads the sine table,
// scales by the amplitude and drives the result word. Uses mwn_pkg.
module mwn_back import mwn_pkg::*; #(
  parameter int ADDR_BITS   = 10,
  parameter int SAMPLE_BITS = 16,
  parameter int TOP_BITS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  fifo_status_t                  fifo_st,
  input  logic [TOP_BITS-1:0]           head_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_value
);

  localparam int     W        = SAMPLE_BITS - 1;
  localparam int     TBL_SIZE = 1 << ADDR_BITS;
  localparam int     PROD_W   = SAMPLE_BITS + AMP_BITS;
  localparam longint HALF_L   = longint'(1) << W;

  localparam logic signed [SAMPLE_BITS-1:0] FULL         = SAMPLE_BITS'(HALF_L - 1);
  localparam logic signed [SAMPLE_BITS+1:0] HALF_X       = (SAMPLE_BITS + 2)'(HALF_L);
  localparam logic signed [SAMPLE_BITS+1:0] THREE_HALF_X = (SAMPLE_BITS + 2)'(3 * HALF_L);
  localparam logic signed [SAMPLE_BITS+1:0] FULL_X       = (SAMPLE_BITS + 2)'(HALF_L - 1);
  localparam logic [PROD_W-1:0]             ROUND_BIAS   = PROD_W'(1 << (AMP_BITS - 1));

  // Quarter-wave sine table, fixed at elaboration and read through a register.
  logic [W-1:0] sine_rom [TBL_SIZE];
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
    assign sine_rom[g] = W'(sine_entry(g, ADDR_BITS, W));
  end

  logic                          adv;
  logic [1:0]                    quad;
  logic [ADDR_BITS-1:0]          idx_raw;
  logic [ADDR_BITS-1:0]          rom_addr;
  logic [SAMPLE_BITS:0]          tri_u;
  logic signed [SAMPLE_BITS+1:0] tri_v;
  logic signed [SAMPLE_BITS-1:0] tri_wave;
  logic signed [SAMPLE_BITS-1:0] alt_wave;

  logic                          s1_valid_r;
  logic                          s1_sine_r;
  logic                          s1_neg_r;
  logic signed [SAMPLE_BITS-1:0] s1_alt_r;
  logic [W-1:0]                  rom_q_r;

  logic                          s2_valid_r;
  logic                          s2_neg_r;
  logic [SAMPLE_BITS-1:0]        s2_mag_r;
  logic                          mag_neg_nxt;
  logic [SAMPLE_BITS-1:0]        mag_nxt;

  logic                          s3_valid_r;
  logic                          s3_neg_r;
  logic [SAMPLE_BITS-1:0]        s3_scaled_r;
  logic [PROD_W-1:0]             prod_sum;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  // The whole pipe moves unless a finished word is held at the output.
  assign adv       = !(out_valid_r && out_stall);
  assign pop       = adv && !fifo_st.empty;
  assign out_valid = out_valid_r;
  assign out_sample_value = out_sample_r;

  // Quadrant and table index; odd quadrants read the table mirrored.
  assign quad     = head_data[TOP_BITS-1 -: 2];
  assign idx_raw  = head_data[TOP_BITS-3 -: ADDR_BITS];
  assign rom_addr = quad[0] ? ~idx_raw : idx_raw;

  // Triangle rises from -1 to +1 over the first half and falls back after.
  assign tri_u = head_data[TOP_BITS-1 -: SAMPLE_BITS + 1];
  always_comb begin
    if (!tri_u[SAMPLE_BITS]) begin
      tri_v = $signed({1'b0, tri_u}) - HALF_X;
    end else begin
      tri_v = THREE_HALF_X - $signed({1'b0, tri_u});
    end
    tri_wave = (tri_v > FULL_X) ? FULL : tri_v[SAMPLE_BITS-1:0];
  end

  // Waveforms that need no table.
  always_comb begin
    unique case (cfg.waveform)
      WAVE_SINE:     alt_wave = '0;
      WAVE_SQUARE:   alt_wave = head_data[TOP_BITS-1] ? -FULL : FULL;
      WAVE_TRIANGLE: alt_wave = tri_wave;
      WAVE_SAW:      alt_wave = $signed(head_data[TOP_BITS-1 -: SAMPLE_BITS]);
      default:       alt_wave = '0;
    endcase
  end

  // Split each wave into sign and magnitude.
  always_comb begin
    if (s1_sine_r) begin
      mag_neg_nxt = s1_neg_r;
      mag_nxt     = {1'b0, rom_q_r};
    end else begin
      mag_neg_nxt = s1_alt_r[SAMPLE_BITS-1];
      mag_nxt     = mag_neg_nxt ? SAMPLE_BITS'(-s1_alt_r) : SAMPLE_BITS'(s1_alt_r);
    end
  end

  // Amplitude scaling, rounded half up on the magnitude.
  assign prod_sum = PROD_W'(s2_mag_r) * PROD_W'(cfg.amplitude) + ROUND_BIAS;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !fifo_st.empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Stage payloads, including the registered table read.
  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r      <= sine_rom[rom_addr];
      s1_sine_r    <= (cfg.waveform == WAVE_SINE);
      s1_neg_r     <= quad[1];
      s1_alt_r     <= alt_wave;
      s2_neg_r     <= mag_neg_nxt;
      s2_mag_r     <= mag_nxt;
      s3_neg_r     <= s2_neg_r;
      s3_scaled_r  <= prod_sum[PROD_W-1 -: SAMPLE_BITS];
      out_sample_r <= s3_neg_r ? -$signed(s3_scaled_r) : $signed(s3_scaled_r);
    end
  end

endmodule

// ===== rtl/multi_waveform_nco_top.sv =====
// Channel    | Ports                                    | Word
// input      | in_valid, in_stall, in_phase_increment   | phase step per sample
// result     | out_valid, out_stall, out_sample_value   | scaled sample, signed
// config     | cfg_wr_en, cfg_index, cfg_wdata          | waveform, amplitude
//
// One word per cycle sustained while the result side is not stalled; each result
// passes through the queue, the table read register and the magnitude, multiply
// and sign stages. The phase accumulator updates once per taken word.
// Reset clears the phase, the queue and all valid bits; registers return to
// triangle at half scale. A stalled result holds the whole back end; the
// four-entry queue keeps taking words until it fills.
// Depends on mwn_pkg, mwn_front, mwn_fifo and mwn_back.
module multi_waveform_nco_top import mwn_pkg::*; #(
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS          = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_phase_increment,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_value,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata
);

  // Phase bits the back end needs: the table address plus quadrant, or the
  // triangle's fold point, whichever is wider.
  localparam int TOP_BITS = (SINE_TABLE_ADDR_BITS + 2 > SAMPLE_BITS + 1) ?
                            SINE_TABLE_ADDR_BITS + 2 : SAMPLE_BITS + 1;

  cfg_t                cfg_r;
  cfg_t                cfg_nxt;
  fifo_status_t        fifo_st;
  logic                push;
  logic                pop;
  logic [TOP_BITS-1:0] push_data;
  logic [TOP_BITS-1:0] head_data;

  // Register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_WAVEFORM) begin
        cfg_nxt.waveform = wave_t'(cfg_wdata[WAVE_SEL_BITS-1:0]);
      end else if (cfg_index == CFG_IDX_AMPLITUDE) begin
        cfg_nxt.amplitude = cfg_wdata[AMP_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform  <= WAVE_RESET;
      cfg_r.amplitude <= AMP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mwn_front #(
    .PHASE_BITS (PHASE_BITS),
    .TOP_BITS   (TOP_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_phase_increment (in_phase_increment),
    .in_stall           (in_stall),
    .fifo_st            (fifo_st),
    .push               (push),
    .push_data          (push_data)
  );

  mwn_fifo #(
    .WIDTH (TOP_BITS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head_data),
    .status    (fifo_st)
  );

  mwn_back #(
    .ADDR_BITS   (SINE_TABLE_ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TOP_BITS    (TOP_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .fifo_st          (fifo_st),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value)
  );

endmodule

// ===== rtl/mwn_checker.sv =====
// Port-level checks for the oscillator, bound to the top level.
// Depends on multi_waveform_nco_top_defines.svh for the assertion macros.
`include "multi_waveform_nco_top_defines.svh"

module mwn_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_value
);

  // A stalled result word stays offered and unchanged.
  `MWN_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sample_value))

  // One free output cycle always frees a queue slot for the next word.
  `MWN_ASSERT_CLK(a_in_ready_after_drain, !out_stall |=> !in_stall)

  // Reset empties the pipe and opens the input.
  `MWN_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid && !in_stall)

endmodule

bind multi_waveform_nco_top mwn_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mwn_checker (.*);
